// ===== design/siof_pkg.sv =====
package siof_pkg;

   localparam int RANGE_W = 16;
   localparam int CLASS_W = 2;
   localparam int INTEN_W = 16;

   // range class codes
   localparam logic [CLASS_W-1:0] CLASS_FINITE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_INF    = 2'd1;

   // csr register indexes
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MIN_RANGE = 2'd1;
   localparam logic [1:0] CSR_MAX_RANGE = 2'd2;

   localparam logic [RANGE_W-1:0] THRESHOLD_RST = 16'd100;
   localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 16'd0;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd65534;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one queue entry: the filtered held sample and/or the flushed last sample
   typedef struct packed {
      logic               has_held;
      logic [RANGE_W-1:0] held_range;
      logic [CLASS_W-1:0] held_class;
      logic [INTEN_W-1:0] held_inten;
      logic               has_last;
      logic [RANGE_W-1:0] last_range;
      logic [CLASS_W-1:0] last_class;
      logic [INTEN_W-1:0] last_inten;
   } siof_entry_type;

   typedef struct packed {
      logic           empty;
      siof_entry_type head;
   } siof_queue_status_type;

   // neighbor test: infinite always differs, nan (or code 3) never does
   function automatic logic differs(input logic [RANGE_W-1:0] cur,
                                    input logic [RANGE_W-1:0] nr,
                                    input logic [CLASS_W-1:0] nc,
                                    input logic [RANGE_W-1:0] thr);
      logic [RANGE_W-1:0] d;
      d = (cur > nr) ? (cur - nr) : (nr - cur);
      if (nc == CLASS_INF) begin
         return 1'b1;
      end else if (nc != CLASS_FINITE) begin
         return 1'b0;
      end else begin
         return d > thr;
      end
   endfunction

endpackage

// ===== design/siof_front.sv =====
module siof_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [siof_pkg::RANGE_W-1:0]    in_range,
   input  logic [siof_pkg::CLASS_W-1:0]    in_class,
   input  logic [siof_pkg::INTEN_W-1:0]    in_inten,
   input  logic                            in_last,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [siof_pkg::RANGE_W-1:0]    csr_wdata,
   output logic                            push,
   output siof_pkg::siof_entry_type        push_entry
);

   logic [siof_pkg::RANGE_W-1:0] thr_ff, min_ff, max_ff;
   logic [siof_pkg::RANGE_W-1:0] held_range_ff, held_range_in;
   logic [siof_pkg::CLASS_W-1:0] held_class_ff, held_class_in;
   logic [siof_pkg::INTEN_W-1:0] held_inten_ff, held_inten_in;
   logic                         held_first_ff, held_first_in;
   logic                         holding_ff, holding_in;
   logic [siof_pkg::RANGE_W-1:0] prior_range_ff, prior_range_in;
   logic [siof_pkg::CLASS_W-1:0] prior_class_ff, prior_class_in;

   logic                         remove;
   logic [siof_pkg::CLASS_W-1:0] oc;
   logic [siof_pkg::RANGE_W-1:0] orange;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= siof_pkg::THRESHOLD_RST;
         min_ff <= siof_pkg::MIN_RANGE_RST;
         max_ff <= siof_pkg::MAX_RANGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            siof_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata;
            siof_pkg::CSR_MIN_RANGE: min_ff <= csr_wdata;
            siof_pkg::CSR_MAX_RANGE: max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      remove = !held_first_ff && (held_class_ff == siof_pkg::CLASS_FINITE) &&
               (held_range_ff >= min_ff) && (held_range_ff <= max_ff) &&
               siof_pkg::differs(held_range_ff, prior_range_ff, prior_class_ff, thr_ff) &&
               siof_pkg::differs(held_range_ff, in_range, in_class, thr_ff);
      oc     = remove ? siof_pkg::CLASS_INF : held_class_ff;
      orange = (oc == siof_pkg::CLASS_FINITE) ? held_range_ff : '0;

      push = accept && (holding_ff || in_last);
      push_entry.has_held   = holding_ff;
      push_entry.held_range = orange;
      push_entry.held_class = oc;
      push_entry.held_inten = remove ? '0 : held_inten_ff;
      push_entry.has_last   = in_last;
      push_entry.last_range = (in_class == siof_pkg::CLASS_FINITE) ? in_range : '0;
      push_entry.last_class = in_class;
      push_entry.last_inten = in_inten;

      held_range_in  = held_range_ff;
      held_class_in  = held_class_ff;
      held_inten_in  = held_inten_ff;
      held_first_in  = held_first_ff;
      holding_in     = holding_ff;
      prior_range_in = prior_range_ff;
      prior_class_in = prior_class_ff;

      if (accept) begin
         if (holding_ff) begin
            prior_range_in = orange;
            prior_class_in = oc;
            held_first_in  = 1'b0;
            if (in_last) begin
               holding_in = 1'b0;
            end else begin
               held_range_in = in_range;
               held_class_in = in_class;
               held_inten_in = in_inten;
            end
         end else if (in_last) begin
            prior_range_in = push_entry.last_range;
            prior_class_in = in_class;
         end else begin
            held_range_in = in_range;
            held_class_in = in_class;
            held_inten_in = in_inten;
            held_first_in = 1'b1;
            holding_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff     <= 1'b0;
         held_first_ff  <= 1'b0;
         held_range_ff  <= '0;
         held_class_ff  <= '0;
         held_inten_ff  <= '0;
         prior_range_ff <= '0;
         prior_class_ff <= '0;
      end else begin
         holding_ff     <= holding_in;
         held_first_ff  <= held_first_in;
         held_range_ff  <= held_range_in;
         held_class_ff  <= held_class_in;
         held_inten_ff  <= held_inten_in;
         prior_range_ff <= prior_range_in;
         prior_class_ff <= prior_class_in;
      end
   end

endmodule

// ===== design/siof_queue.sv =====
module siof_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  siof_pkg::siof_entry_type         push_entry,
   input  logic                             pop,
   output logic                             full,
   output siof_pkg::siof_queue_status_type  status
);

   siof_pkg::siof_entry_type             mem_ff [siof_pkg::QUEUE_DEPTH];
   logic [siof_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [siof_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full         = (count_ff == siof_pkg::QUEUE_CNT_W'(siof_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/siof_back.sv =====
module siof_back (
   input  logic                             clock,
   input  logic                             reset,
   input  siof_pkg::siof_queue_status_type  status,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   logic phase_ff, phase_in;
   logic held_part;
   logic take;

   always_comb begin
      held_part  = status.head.has_held && !phase_ff;
      rsp_tvalid = !status.empty;
      take       = rsp_tvalid && rsp_tready;
      if (held_part) begin
         rsp_tdata = {status.head.held_inten, status.head.held_range};
         rsp_tuser = status.head.held_class;
         rsp_tlast = 1'b0;
      end else begin
         rsp_tdata = {status.head.last_inten, status.head.last_range};
         rsp_tuser = status.head.last_class;
         rsp_tlast = 1'b1;
      end
      // a held plus last entry goes out in two beats
      pop      = 1'b0;
      phase_in = phase_ff;
      if (take) begin
         if (held_part && status.head.has_last) begin
            phase_in = 1'b1;
         end else begin
            pop      = 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== design/scan_isolated_outlier_filter.sv =====
// Isolated point removal for a laser scan. Range samples come in order, one
// request per cycle; each result is the filtered sample one position behind
// the input, and the final sample of a scan (tlast) is flushed right after
// its predecessor, so a last sample can produce two results. An interior
// finite sample inside [min, max] is replaced by infinite with intensity 0
// when it differs by more than the threshold from both the filtered previous
// sample and the raw next one (infinite neighbor: differs; nan: never).
// Rate: one request per cycle while not full; the output side drains one
// result per cycle while rsp_tready is high, so a scan of N samples takes N
// output beats. A 4-entry queue between the classifier and output expander
// absorbs the extra beat of a flush and output stalls; req_tready drops
// only when it is full. Config writes (csr_*) take effect on the next cycle.
module scan_isolated_outlier_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] range_mm, [31:16] intensity
   input  logic [1:0]  req_tuser,   // [1:0] range_class
   input  logic        req_tlast,   // last_in_scan
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_range_mm, [31:16] out_intensity
   output logic [1:0]  rsp_tuser,   // [1:0] out_range_class
   output logic        rsp_tlast,   // out_last_in_scan
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                            accept;
   logic                            full;
   logic                            push;
   logic                            pop;
   siof_pkg::siof_entry_type        push_entry;
   siof_pkg::siof_queue_status_type status;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // front: holds one sample, decides removal once its successor shows up
   siof_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_range   (req_tdata[15:0]),
      .in_class   (req_tuser),
      .in_inten   (req_tdata[31:16]),
      .in_last    (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry)
   );

   siof_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .status     (status)
   );

   // back: expands each entry into one or two result beats
   siof_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
